// ===== src/simd_long_wide_narrow_alu_unit_defines.svh =====
// Assertion macros for the SIMD long/wide/narrow ALU.
`ifndef SIMD_LONG_WIDE_NARROW_ALU_UNIT_DEFINES_SVH
`define SIMD_LONG_WIDE_NARROW_ALU_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SLWN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLWN_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SLWN_ASSERT(lbl, prop, msg)
`define SLWN_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/slwn_pkg.sv =====
// Shared operation codes and control types for the SIMD long/wide/narrow ALU.
`timescale 1ns / 1ps
package slwn_pkg;
    localparam logic [4:0] OP_ADDL   = 5'd0;
    localparam logic [4:0] OP_ADDW   = 5'd1;
    localparam logic [4:0] OP_SUBL   = 5'd2;
    localparam logic [4:0] OP_SUBW   = 5'd3;
    localparam logic [4:0] OP_ADDHN  = 5'd4;
    localparam logic [4:0] OP_RADDHN = 5'd5;
    localparam logic [4:0] OP_SUBHN  = 5'd6;
    localparam logic [4:0] OP_RSUBHN = 5'd7;
    localparam logic [4:0] OP_ABDL   = 5'd8;
    localparam logic [4:0] OP_ABAL   = 5'd9;
    localparam logic [4:0] OP_MULL   = 5'd10;
    localparam logic [4:0] OP_MLAL   = 5'd11;
    localparam logic [4:0] OP_MLSL   = 5'd12;
    localparam logic [4:0] OP_PMULL  = 5'd13;
    localparam logic [4:0] OP_QDMULL = 5'd14;
    localparam logic [4:0] OP_QDMLAL = 5'd15;
    localparam logic [4:0] OP_QDMLSL = 5'd16;

    localparam logic [1:0] ES_8  = 2'd0;
    localparam logic [1:0] ES_16 = 2'd1;
    localparam logic [1:0] ES_32 = 2'd2;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] es;
    } ctrl_t;
endpackage

// ===== src/simd_long_wide_narrow_alu_unit.sv =====
// Top level of the SIMD long/wide/narrow ALU: lane groups, pipeline control and merge.
//
//  channel | dir | tdata (low bit up)                    | tuser (low bit up)
//  s_axis  | in  | first_low, first_high, second_low,    | operation[4:0], element_size[6:5],
//          |     | second_high, accum_low, accum_high    | unsigned_mode[7]
//  m_axis  | out | result_low, result_high               | narrow_result[0], saturated[1]
//
// One instruction per cycle sustained unless the output stalls. Stage one preps operands
// and runs the lane multipliers (up to 32x32 in the 32-bit group); stage two does
// the accumulate or saturating add, and the merge loads the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled output beat holds the whole pipeline; s_axis_tready drops only then.
`timescale 1ns / 1ps
`include "simd_long_wide_narrow_alu_unit_defines.svh"
module simd_long_wide_narrow_alu_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,   // first_low, first_high, second_low, second_high,
                                         // accum_low, accum_high
    input  logic [7:0]   s_axis_tuser,   // operation, element_size, unsigned_mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_low, result_high
    output logic [1:0]   m_axis_tuser    // narrow_result, saturated
);
    import slwn_pkg::*;

    // Unpack the beat.
    logic [63:0]  first_low, first_high, second_low, second_high, accum_low, accum_high;
    logic [4:0]   operation;
    logic [1:0]   element_size;
    logic         unsigned_mode;
    logic [127:0] first_w, second_w, accum_w;

    assign first_low     = s_axis_tdata[63:0];
    assign first_high    = s_axis_tdata[127:64];
    assign second_low    = s_axis_tdata[191:128];
    assign second_high   = s_axis_tdata[255:192];
    assign accum_low     = s_axis_tdata[319:256];
    assign accum_high    = s_axis_tdata[383:320];
    assign operation     = s_axis_tuser[4:0];
    assign element_size  = s_axis_tuser[6:5];
    assign unsigned_mode = s_axis_tuser[7];
    assign first_w       = {first_high, first_low};
    assign second_w      = {second_high, second_low};
    assign accum_w       = {accum_high, accum_low};

    // Pipeline control: every stage advances together when the output is free.
    logic  v1_reg, v1_next, v2_reg, v2_next;
    logic  advance;
    ctrl_t ctrl1_reg;

    assign advance       = !v2_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign v1_next       = advance ? s_axis_tvalid : v1_reg;
    assign v2_next       = advance ? v1_reg : v2_reg;
    assign m_axis_tvalid = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctrl1_reg.op <= operation;
            ctrl1_reg.es <= element_size;
        end
    end

    // Three lane groups, one per narrow element width; the merge picks one.
    logic [127:0] wide8, wide16, wide32;
    logic [7:0]   sat8;
    logic [3:0]   sat16;
    logic [1:0]   sat32;

    for (genvar i = 0; i < 8; i++)
    begin : g_l8
        slwn_lane #(.LW(8)) u_lane (
            .clk    (clk),
            .en     (advance),
            .op     (operation),
            .un     (unsigned_mode),
            .x      (first_low[i*8 +: 8]),
            .y      (second_low[i*8 +: 8]),
            .a_wide (first_w[i*16 +: 16]),
            .b_wide (second_w[i*16 +: 16]),
            .acc    (accum_w[i*16 +: 16]),
            .res    (wide8[i*16 +: 16]),
            .sat    (sat8[i])
        );
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_l16
        slwn_lane #(.LW(16)) u_lane (
            .clk    (clk),
            .en     (advance),
            .op     (operation),
            .un     (unsigned_mode),
            .x      (first_low[i*16 +: 16]),
            .y      (second_low[i*16 +: 16]),
            .a_wide (first_w[i*32 +: 32]),
            .b_wide (second_w[i*32 +: 32]),
            .acc    (accum_w[i*32 +: 32]),
            .res    (wide16[i*32 +: 32]),
            .sat    (sat16[i])
        );
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_l32
        slwn_lane #(.LW(32)) u_lane (
            .clk    (clk),
            .en     (advance),
            .op     (operation),
            .un     (unsigned_mode),
            .x      (first_low[i*32 +: 32]),
            .y      (second_low[i*32 +: 32]),
            .a_wide (first_w[i*64 +: 64]),
            .b_wide (second_w[i*64 +: 64]),
            .acc    (accum_w[i*64 +: 64]),
            .res    (wide32[i*64 +: 64]),
            .sat    (sat32[i])
        );
    end

    // Merge into the output register; load only on a live beat.
    logic [63:0] result_low, result_high;
    logic        narrow_result, saturated;

    slwn_merge u_merge (
        .clk           (clk),
        .load          (advance && v1_reg),
        .ctrl          (ctrl1_reg),
        .wide8         (wide8),
        .wide16        (wide16),
        .wide32        (wide32),
        .sat8          (sat8),
        .sat16         (sat16),
        .sat32         (sat32),
        .result_low    (result_low),
        .result_high   (result_high),
        .narrow_result (narrow_result),
        .saturated     (saturated)
    );

    assign m_axis_tdata = {result_high, result_low};
    assign m_axis_tuser = {saturated, narrow_result};

    `SLWN_ASSERT(a_narrow_high_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:64] == 64'd0, "narrow result with nonzero high doubleword")
    `SLWN_NEVER(a_sat_not_narrow, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "saturation flagged on a narrowing beat")
    `SLWN_ASSERT(a_stage1_hold, v1_reg && !advance |=> v1_reg, "stage one beat lost during stall")
endmodule

// ===== src/slwn_lane.sv =====
// One narrow lane: operand prep and multiply in stage one, accumulate and clip in stage two.
`timescale 1ns / 1ps
module slwn_lane #(
    parameter int LW = 8
) (
    input  logic            clk,
    input  logic            en,
    input  logic [4:0]      op,
    input  logic            un,
    input  logic [LW-1:0]   x,
    input  logic [LW-1:0]   y,
    input  logic [2*LW-1:0] a_wide,
    input  logic [2*LW-1:0] b_wide,
    input  logic [2*LW-1:0] acc,
    output logic [2*LW-1:0] res,
    output logic            sat
);
    import slwn_pkg::*;

    localparam int DW = 2 * LW;

    logic [4:0]    op_reg;
    logic [DW-1:0] val_reg, val_next;
    logic [DW-1:0] acc_reg;
    logic          psat_reg, psat_next;

    logic              sgn;
    logic [DW-1:0]     ext_x, ext_y, a_sel, hsum;
    logic signed [LW:0]   xe, ye;
    logic signed [LW+1:0] dif;
    logic [LW+1:0]        adif;
    logic signed [DW+1:0] prod;
    logic [DW-1:0]        pm;
    logic [DW-1:0]        sb;
    logic                 both_min;

    always_comb
    begin
        sgn      = (op >= OP_QDMULL) ? 1'b1 : !un;
        ext_x    = {{LW{sgn & x[LW-1]}}, x};
        ext_y    = {{LW{sgn & y[LW-1]}}, y};
        xe       = $signed({sgn & x[LW-1], x});
        ye       = $signed({sgn & y[LW-1], y});
        dif      = xe - ye;
        adif     = dif[LW+1] ? LW'(0) - dif : dif;
        prod     = xe * ye;
        sb       = DW'(1) << (DW - 1);
        both_min = (x == (LW'(1) << (LW - 1))) && (y == (LW'(1) << (LW - 1)));
        pm       = '0;
        for (int i = 0; i < LW; i++)
        begin
            if (x[i])
                pm = pm ^ (DW'(y) << i);
        end
        a_sel = (op == OP_ADDW || op == OP_SUBW) ? a_wide : ext_x;
        hsum  = (op >= OP_SUBHN) ? a_wide - b_wide : a_wide + b_wide;
        if (op == OP_RADDHN || op == OP_RSUBHN)
            hsum = hsum + (DW'(1) << (LW - 1));
        psat_next = 1'b0;
        case (op)
            OP_ADDL, OP_ADDW:                 val_next = a_sel + ext_y;
            OP_SUBL, OP_SUBW:                 val_next = a_sel - ext_y;
            OP_ADDHN, OP_RADDHN, OP_SUBHN, OP_RSUBHN:
                                              val_next = {LW'(0), hsum[DW-1:LW]};
            OP_ABDL, OP_ABAL:                 val_next = DW'(adif[LW:0]);
            OP_MULL, OP_MLAL, OP_MLSL:        val_next = prod[DW-1:0];
            OP_PMULL:                         val_next = pm;
            OP_QDMULL, OP_QDMLAL, OP_QDMLSL:
            begin
                if (both_min)
                begin
                    val_next  = sb - DW'(1);
                    psat_next = 1'b1;
                end
                else
                begin
                    val_next = {prod[DW-2:0], 1'b0};
                end
            end
            default:                          val_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op;
            val_reg  <= val_next;
            acc_reg  <= acc;
            psat_reg <= psat_next;
        end
    end

    logic [DW-1:0] c;
    logic          ovf;

    always_comb
    begin
        c   = (op_reg == OP_QDMLSL) ? acc_reg - val_reg : acc_reg + val_reg;
        ovf = (op_reg == OP_QDMLSL)
            ? (acc_reg[DW-1] != val_reg[DW-1]) && (c[DW-1] != acc_reg[DW-1])
            : (acc_reg[DW-1] == val_reg[DW-1]) && (c[DW-1] != acc_reg[DW-1]);
        res = val_reg;
        sat = 1'b0;
        case (op_reg)
            OP_ABAL, OP_MLAL: res = acc_reg + val_reg;
            OP_MLSL:          res = acc_reg - val_reg;
            OP_QDMULL:        sat = psat_reg;
            OP_QDMLAL, OP_QDMLSL:
            begin
                sat = psat_reg | ovf;
                if (ovf)
                    res = acc_reg[DW-1] ? sb : sb - DW'(1);
                else
                    res = c;
            end
            default:          res = val_reg;
        endcase
    end
endmodule

// ===== src/slwn_merge.sv =====
// Lane-group select, narrow packing and saturation merge into the output register.
`timescale 1ns / 1ps
module slwn_merge (
    input  logic                 clk,
    input  logic                 load,
    input  slwn_pkg::ctrl_t      ctrl,
    input  logic [127:0]         wide8,
    input  logic [127:0]         wide16,
    input  logic [127:0]         wide32,
    input  logic [7:0]           sat8,
    input  logic [3:0]           sat16,
    input  logic [1:0]           sat32,
    output logic [63:0]          result_low,
    output logic [63:0]          result_high,
    output logic                 narrow_result,
    output logic                 saturated
);
    import slwn_pkg::*;

    logic [1:0]   esel;
    logic [127:0] wsel;
    logic [63:0]  nsel;
    logic         ssel, nar;
    logic [63:0]  lo_next, hi_next;

    always_comb
    begin
        esel = (ctrl.op == OP_PMULL) ? ES_8 : ((ctrl.es == 2'd3) ? ES_32 : ctrl.es);
        nsel = '0;
        case (esel)
            ES_8:
            begin
                wsel = wide8;
                ssel = |sat8;
                for (int i = 0; i < 8; i++)
                    nsel[i*8 +: 8] = wide8[i*16 +: 8];
            end
            ES_16:
            begin
                wsel = wide16;
                ssel = |sat16;
                for (int i = 0; i < 4; i++)
                    nsel[i*16 +: 16] = wide16[i*32 +: 16];
            end
            default:
            begin
                wsel = wide32;
                ssel = |sat32;
                for (int i = 0; i < 2; i++)
                    nsel[i*32 +: 32] = wide32[i*64 +: 32];
            end
        endcase
        nar = (ctrl.op inside {[OP_ADDHN:OP_RSUBHN]});
        if (ctrl.op > OP_QDMLSL)
        begin
            lo_next = '0;
            hi_next = '0;
            ssel    = 1'b0;
        end
        else if (nar)
        begin
            lo_next = nsel;
            hi_next = '0;
        end
        else
        begin
            lo_next = wsel[63:0];
            hi_next = wsel[127:64];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_low    <= lo_next;
            result_high   <= hi_next;
            narrow_result <= nar;
            saturated     <= ssel;
        end
    end
endmodule

// ===== dv/simd_long_wide_narrow_alu_unit_checker.sv =====
// Result checker for the SIMD long/wide/narrow ALU: predicts each beat and compares.
`timescale 1ns / 1ps
module simd_long_wide_narrow_alu_unit_checker
    import slwn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,
    input  logic [7:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           error_count,
    output int           pending_count
);
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        narrow;
        logic        sat;
    } alu_result_t;

    alu_result_t result_fifo[$];

    function automatic logic [63:0] wmask(int unsigned w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] sign_ext(logic [63:0] v, int unsigned w);
        logic [63:0] m;
        if (w >= 64)
            return v;
        m = 64'd1 << (w - 1);
        return ((v & wmask(w)) ^ m) - m;
    endfunction

    // Fetch a double-width lane from a 128-bit pair.
    function automatic logic [63:0] dlane(logic [127:0] v, int unsigned e, int unsigned w);
        logic [127:0] t;
        t = v >> (e * w);
        return t[63:0] & wmask(w);
    endfunction

    function automatic alu_result_t predict_alu(logic [7:0] user, logic [383:0] data);
        logic [4:0]   op;
        logic [1:0]   es;
        logic         un;
        logic [127:0] f, s, acc, res;
        logic [63:0]  x, y, a, b, r, p, minraw, sb, c;
        int unsigned  w, ww, n;
        logic         ovf;
        alu_result_t  o;
        op = user[4:0];
        es = user[6:5];
        un = user[7];
        f = data[127:0];
        s = data[255:128];
        acc = data[383:256];
        res = '0;
        o = '0;
        if (es > ES_32)
            es = ES_32;
        if (op == OP_PMULL)
            es = ES_8;
        w = 8 << es;
        ww = 2 * w;
        n = 64 / w;
        if (op > OP_QDMLSL)
            return o;
        for (int e = 0; e < n; e++)
        begin
            x = (f[63:0] >> (e * w)) & wmask(w);
            y = (s[63:0] >> (e * w)) & wmask(w);
            r = '0;
            if (op <= OP_SUBW)
            begin
                a = op[0] ? dlane(f, e, ww) : x;
                b = y;
                if (!un)
                begin
                    a = sign_ext(a, op[0] ? ww : w);
                    b = sign_ext(b, w);
                end
                r = (op >= OP_SUBL) ? a - b : a + b;
            end
            else if (op <= OP_RSUBHN)
            begin
                a = dlane(f, e, ww);
                b = dlane(s, e, ww);
                r = (op >= OP_SUBHN) ? a - b : a + b;
                if (op[0])
                    r += 64'd1 << (w - 1);
                r = (r >> w) & wmask(w);
                res[63:0] |= r << (e * w);
                o.narrow = 1'b1;
                continue;
            end
            else if (op <= OP_ABAL)
            begin
                a = x;
                b = y;
                if (!un)
                begin
                    a = sign_ext(x, w) ^ (64'd1 << 63);
                    b = sign_ext(y, w) ^ (64'd1 << 63);
                end
                r = (a >= b) ? a - b : b - a;
                if (op == OP_ABAL)
                    r += dlane(acc, e, ww);
            end
            else if (op <= OP_MLSL)
            begin
                p = un ? x * y : sign_ext(x, w) * sign_ext(y, w);
                if (op == OP_MULL)
                    r = p;
                else if (op == OP_MLAL)
                    r = dlane(acc, e, ww) + p;
                else
                    r = dlane(acc, e, ww) - p;
            end
            else if (op == OP_PMULL)
            begin
                for (int i = 0; i < 8; i++)
                    if (x[i])
                        r ^= y << i;
            end
            else
            begin
                minraw = 64'd1 << (w - 1);
                sb = 64'd1 << (ww - 1);
                if (x == minraw && y == minraw)
                begin
                    p = sb - 1;
                    o.sat = 1'b1;
                end
                else
                    p = (sign_ext(x, w) * sign_ext(y, w)) << 1;
                if (op == OP_QDMULL)
                    r = p;
                else
                begin
                    a = sign_ext(dlane(acc, e, ww), ww);
                    c = (op == OP_QDMLSL) ? a - p : a + p;
                    if (op == OP_QDMLSL)
                        ovf = ((a & sb) != (p & sb)) && ((c & sb) != (a & sb));
                    else
                        ovf = ((a & sb) == (p & sb)) && ((c & sb) != (a & sb));
                    if (ovf)
                    begin
                        r = ((a & sb) != 0) ? sb : sb - 1;
                        o.sat = 1'b1;
                    end
                    else
                        r = c;
                end
            end
            res |= {64'd0, r & wmask(ww)} << (e * ww);
        end
        o.lo = res[63:0];
        o.hi = o.narrow ? 64'd0 : res[127:64];
        return o;
    endfunction

    assign pending_count = result_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t exp_r;
        alu_result_t got;
        if (!rst_n)
        begin
            error_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                result_fifo.push_back(predict_alu(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser[0],
                       m_axis_tuser[1]};
                if (result_fifo.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: unexpected result beat %h", $realtime, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    exp_r = result_fifo.pop_front();
                    if (got !== exp_r)
                    begin
                        if (error_count < 10)
                            $display("%0t: mismatch lo %h/%h hi %h/%h narrow %b/%b sat %b/%b",
                                     $realtime, exp_r.lo, got.lo, exp_r.hi, got.hi,
                                     exp_r.narrow, got.narrow, exp_r.sat, got.sat);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_simd_long_wide_narrow_alu_unit.sv =====
// Testbench top for the SIMD long/wide/narrow ALU: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_simd_long_wide_narrow_alu_unit;
    import slwn_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic [7:0]   s_axis_tuser = '0;   // operation, element_size, unsigned_mode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // result_low, result_high
    logic [1:0]   m_axis_tuser;        // narrow_result, saturated
    int           error_count;
    int           pending_count;
    bit           hold_off = 1'b0;     // long receiver stall to fill the pipeline

    always #5 clk = ~clk;

    simd_long_wide_narrow_alu_unit u_top (.*);

    simd_long_wide_narrow_alu_unit_checker u_checker (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Bias operand lanes toward corner values so saturation and carries show up.
    function automatic logic [63:0] operand_word(logic [1:0] es);
        logic [63:0] v;
        int unsigned w;
        v = {$urandom, $urandom};
        w = 8 << ((es > ES_32) ? ES_32 : es);
        if ($urandom_range(0, 2) == 0)
            for (int e = 0; e < 64 / w; e++)
                case ($urandom_range(0, 3))
                    0: v = (v & ~(((64'd1 << w) - 1) << (e * w)))
                           | ((64'd1 << (w - 1)) << (e * w));
                    1: v = v & ~(((64'd1 << w) - 1) << (e * w));
                    2: v = v | (((64'd1 << w) - 1) << (e * w));
                    default: ;
                endcase
        return v;
    endfunction

    // Offer one instruction beat and hold it until accepted.
    task automatic send_beat(logic [4:0] op, logic [1:0] es, logic un, logic [383:0] data);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {un, es, op};
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(logic [4:0] op, logic [1:0] es, logic un);
        logic [383:0] d;
        for (int k = 0; k < 6; k++)
            d[k*64 +: 64] = operand_word(es);
        send_beat(op, es, un, d);
    endtask

    // Receiver: random stalls, with one long hold-off on request.
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
            begin
                gap = gap_len();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        // Directed: every op at 8-bit lane size in signed mode with all-one operands,
        // then saturating ops with MIN operands, size code 3, unused opcodes and all-zero data.
        for (int op = 0; op <= 16; op++)
            send_beat(op[4:0], ES_8, 1'b0, {384{1'b1}});
        send_beat(OP_QDMULL, ES_8, 1'b0, {6{64'h8080_8080_8080_8080}});
        send_beat(OP_QDMULL, ES_16, 1'b0, {6{64'h8000_8000_8000_8000}});
        send_beat(OP_QDMLAL, ES_32, 1'b0,
                  {64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, {4{64'h8000_0000_8000_0000}}});
        send_beat(OP_QDMLSL, ES_32, 1'b0,
                  {{2{64'h8000_0000_0000_0000}}, {4{64'h8000_0000_8000_0000}}});
        send_beat(OP_PMULL, ES_32, 1'b1, {384{1'b1}});
        send_beat(OP_ABDL, 2'd3, 1'b1, {192{2'b10}});
        send_beat(5'd17, ES_16, 1'b1, {384{1'b1}});
        send_beat(5'd31, ES_32, 1'b0, '0);
        // Pressure: receiver stalls while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_random(5'($urandom_range(0, 16)), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
        join
        for (int i = 0; i < 1730; i++)
            send_random(($urandom_range(0, 40) == 0) ? 5'($urandom_range(17, 31))
                                                     : 5'($urandom_range(0, 16)),
                        2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/slwn_pkg.sv
src/slwn_lane.sv
src/slwn_merge.sv
src/simd_long_wide_narrow_alu_unit.sv
dv/simd_long_wide_narrow_alu_unit_checker.sv
dv/tb_simd_long_wide_narrow_alu_unit.sv
